// ===== rtl/core/mts_pkg.sv =====
// Shared types and constants for the max-tracking stack.
package mts_pkg;

  // Stack depth and derived widths
  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO  = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // Request item
  typedef struct packed {
    logic                     req_type;
    logic signed [DATA_W-1:0] push_value;
  } mts_req_t;

  // Result item
  typedef struct packed {
    logic signed [DATA_W-1:0] popped_value;
    logic signed [DATA_W-1:0] current_max;
    logic                     is_empty;
    logic [1:0]               status;
  } mts_rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic finish_pop;
  } mts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic needs_read;
  } mts_stat_t;

endpackage

// ===== rtl/core/mts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mts_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic                                       re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// Sequencing controller for the max-tracking stack.
module mts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output logic              done_o,
  output mts_pkg::mts_cmd_t cmd_o,
  input  mts_pkg::mts_stat_t stat_i
);

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_e;

  state_e state_q;
  logic   done_q;

  // Commands follow from the state and the handshake
  assign busy              = (state_q == S_POP);
  assign cmd_o.accept      = start && !busy;
  assign cmd_o.finish_pop  = (state_q == S_POP);

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_o.accept) begin
            if (stat_i.needs_read) begin
              state_q <= S_POP;
            end else begin
              done_q <= 1'b1;
            end
          end
        end
        S_POP: begin
          state_q <= S_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o = done_q;

endmodule

// ===== rtl/core/mts_datapath.sv =====
// Counters, top-of-maxima register, stack memories and result register.
module mts_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mts_pkg::mts_req_t  req_i,
  input  mts_pkg::mts_cmd_t  cmd_i,
  output mts_pkg::mts_stat_t stat_o,
  output mts_pkg::mts_rsp_t  rsp_o
);

  localparam int unsigned AW = mts_pkg::ADDR_W;
  localparam int unsigned CW = mts_pkg::CNT_W;
  localparam int unsigned DW = mts_pkg::DATA_W;

  logic [CW-1:0]        vc_q, vc_d;
  logic [CW-1:0]        mc_q, mc_d;
  logic signed [DW-1:0] max_top_q, max_top_d;
  mts_pkg::mts_rsp_t    rsp_q, rsp_d;
  logic                 rsp_load;

  logic          val_we, max_we, val_re, max_re;
  logic [AW-1:0] val_waddr, max_waddr, val_raddr, max_raddr;
  logic [DW-1:0] val_rdata, max_rdata;
  logic signed [DW-1:0] popped;
  logic [1:0]    status;

  // A pop on a non-empty stack needs the memories read first
  assign stat_o.needs_read = (req_i.req_type == mts_pkg::OP_POP) && (vc_q != mts_pkg::CNT_ZERO);

  // Next-state logic
  always_comb begin
    vc_d      = vc_q;
    mc_d      = mc_q;
    max_top_d = max_top_q;
    val_we    = 1'b0;
    max_we    = 1'b0;
    val_re    = 1'b0;
    max_re    = 1'b0;
    val_waddr = vc_q[AW-1:0];
    max_waddr = mc_q[AW-1:0];
    val_raddr = AW'(vc_q - mts_pkg::CNT_ONE);
    max_raddr = AW'(mc_q - mts_pkg::CNT_TWO);
    popped    = '0;
    status    = mts_pkg::ST_OK;
    rsp_load  = 1'b0;

    if (cmd_i.accept) begin
      if (req_i.req_type == mts_pkg::OP_PUSH) begin
        rsp_load = 1'b1;
        if (vc_q == mts_pkg::CNT_FULL) begin
          status = mts_pkg::ST_OVERFLOW;
        end else begin
          val_we = 1'b1;
          vc_d   = vc_q + mts_pkg::CNT_ONE;
          if ((mc_q == mts_pkg::CNT_ZERO) || (req_i.push_value >= max_top_q)) begin
            if (mc_q != mts_pkg::CNT_FULL) begin
              max_we    = 1'b1;
              mc_d      = mc_q + mts_pkg::CNT_ONE;
              max_top_d = req_i.push_value;
            end
          end
        end
      end else if (vc_q == mts_pkg::CNT_ZERO) begin
        rsp_load = 1'b1;
        status   = mts_pkg::ST_UNDERFLOW;
      end else begin
        // fetch the top value and the maximum below the current one
        val_re = 1'b1;
        max_re = (mc_q >= mts_pkg::CNT_TWO);
      end
    end

    // Complete a pop with the read data
    if (cmd_i.finish_pop) begin
      rsp_load = 1'b1;
      popped   = signed'(val_rdata);
      vc_d     = vc_q - mts_pkg::CNT_ONE;
      if ((mc_q != mts_pkg::CNT_ZERO) && (max_top_q == popped)) begin
        mc_d      = mc_q - mts_pkg::CNT_ONE;
        max_top_d = signed'(max_rdata);
      end
    end

    // Result reflects the state after the operation
    rsp_d.popped_value = popped;
    rsp_d.status       = status;
    rsp_d.is_empty     = (vc_d == mts_pkg::CNT_ZERO);
    rsp_d.current_max  = ((vc_d == mts_pkg::CNT_ZERO) || (mc_d == mts_pkg::CNT_ZERO)) ?
                         '0 : max_top_d;
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= '0;
      mc_q <= '0;
    end else begin
      vc_q <= vc_d;
      mc_q <= mc_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    max_top_q <= max_top_d;
    if (rsp_load) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o = rsp_q;

  // Value stack memory
  mts_ram #(
    .WIDTH(DW),
    .DEPTH(mts_pkg::DEPTH)
  ) u_val_ram (
    .clk_i  (clk_i),
    .we_i   (val_we),
    .waddr_i(val_waddr),
    .wdata_i(req_i.push_value),
    .re_i   (val_re),
    .raddr_i(val_raddr),
    .rdata_o(val_rdata)
  );

  // Maxima stack memory
  mts_ram #(
    .WIDTH(DW),
    .DEPTH(mts_pkg::DEPTH)
  ) u_max_ram (
    .clk_i  (clk_i),
    .we_i   (max_we),
    .waddr_i(max_waddr),
    .wdata_i(req_i.push_value),
    .re_i   (max_re),
    .raddr_i(max_raddr),
    .rdata_o(max_rdata)
  );

endmodule

// ===== rtl/core/max_tracking_stack_core.sv =====
// Top level of the max-tracking stack: controller plus datapath.
//
//   channel   ports                 handshake
//   request   req_i                 taken when start && !busy
//   result    rsp_o                 valid for one cycle while done_o is high
//
// A push, an overflow and an underflow finish without a busy phase: done_o rises on
// the cycle after the request is taken and busy stays low. A pop of a held
// value passes through the S_POP state because the top entry comes out of the value RAM's
// registered read port; busy is high while the controller is in S_POP.
// Reset empties both stacks; memory contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module max_tracking_stack_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  mts_pkg::mts_req_t req_i,
  output logic              done_o,
  output mts_pkg::mts_rsp_t rsp_o
);

  mts_pkg::mts_cmd_t  cmd;
  mts_pkg::mts_stat_t stat;

  // Sequencer
  mts_ctrl u_ctrl (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start (start),
    .busy  (busy),
    .done_o(done_o),
    .cmd_o (cmd),
    .stat_i(stat)
  );

  // Stack storage and arithmetic
  mts_datapath u_datapath (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_i),
    .cmd_i (cmd),
    .stat_o(stat),
    .rsp_o (rsp_o)
  );

endmodule

// ===== sim/max_tracking_stack_core_tb.sv =====
// Self-checking testbench for the max-tracking stack core: push/pop stimulus plus scoreboard.
`timescale 1ns / 100ps

module max_tracking_stack_core_tb;

  localparam int unsigned QUIET_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Stack model and the queue of results the block still owes
  class max_stack_scoreboard;
    logic signed [mts_pkg::DATA_W-1:0] value_mem [mts_pkg::DEPTH];
    logic signed [mts_pkg::DATA_W-1:0] max_mem [mts_pkg::DEPTH];
    int unsigned                       value_cnt;
    int unsigned                       max_cnt;
    mts_pkg::mts_rsp_t                 awaited_q [$];
    int unsigned                       mismatches;

    function new();
      value_cnt  = 0;
      max_cnt    = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted item to the model and queue its result
    function void note_request(mts_pkg::mts_req_t req);
      logic signed [mts_pkg::DATA_W-1:0] val;
      mts_pkg::mts_rsp_t                 rsp;
      val        = req.push_value;
      rsp        = '0;
      rsp.status = mts_pkg::ST_OK;
      if (req.req_type == mts_pkg::OP_PUSH) begin
        if (value_cnt >= mts_pkg::DEPTH) begin
          rsp.status = mts_pkg::ST_OVERFLOW;
        end else begin
          value_mem[value_cnt] = val;
          value_cnt++;
          // equal values enter the max stack too, so duplicates pop cleanly
          if (max_cnt == 0 || val >= max_mem[max_cnt-1]) begin
            if (max_cnt < mts_pkg::DEPTH) begin
              max_mem[max_cnt] = val;
              max_cnt++;
            end
          end
        end
      end else begin
        if (value_cnt == 0) begin
          rsp.status = mts_pkg::ST_UNDERFLOW;
        end else begin
          rsp.popped_value = value_mem[value_cnt-1];
          if (max_cnt > 0 && max_mem[max_cnt-1] == rsp.popped_value) max_cnt--;
          value_cnt--;
        end
      end
      rsp.current_max = (value_cnt == 0 || max_cnt == 0) ? '0 : max_mem[max_cnt-1];
      rsp.is_empty    = (value_cnt == 0);
      awaited_q.insert(awaited_q.size(), rsp);
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(mts_pkg::mts_rsp_t got);
      mts_pkg::mts_rsp_t want;
      if (awaited_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected result pop=%0d max=%0d empty=%0b st=%0d",
                   got.popped_value, got.current_max, got.is_empty, got.status);
        return;
      end
      want = awaited_q.pop_front();
      if (got.popped_value !== want.popped_value || got.current_max !== want.current_max ||
          got.is_empty !== want.is_empty || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: expected pop=%0d max=%0d empty=%0b st=%0d, got pop=%0d max=%0d %s",
                   want.popped_value, want.current_max, want.is_empty, want.status,
                   got.popped_value, got.current_max,
                   $sformatf("empty=%0b st=%0d", got.is_empty, got.status));
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              done_o;
  mts_pkg::mts_req_t req_i;
  mts_pkg::mts_rsp_t rsp_o;

  max_stack_scoreboard stack_sb = new();
  int unsigned         quiet_cycles = 0;
  bit                  idle_ok = 1'b1;

  max_tracking_stack_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result monitor and stall watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) stack_sb.check_result(rsp_o);
      if (done_o || (start && !busy)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Present one item, with an occasional random idle cycle ahead of it
  task automatic send_item(logic op, logic signed [mts_pkg::DATA_W-1:0] val);
    int unsigned gap;
    gap = 0;
    if (idle_ok && $urandom_range(99) < 9) gap = 1;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{req_type: op, push_value: val};
    do @(posedge clk_i); while (busy);
    stack_sb.note_request(req_i);
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    while (stack_sb.awaited_q.size() != 0) @(posedge clk_i);
  endtask

  // Small values give duplicates and ties with the max; the rest span the range
  function automatic logic signed [mts_pkg::DATA_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(9);
    if (r < 4) return int'($urandom_range(8)) - 4;
    if (r == 8) return 32'sh7FFF_FFFF;
    if (r == 9) return 32'sh8000_0000;
    return $urandom;
  endfunction

  task automatic run_mixed(int unsigned n, int unsigned push_pct);
    repeat (n)
      send_item(($urandom_range(99) < push_pct) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP,
                pick_value());
  endtask

  initial begin
    logic signed [mts_pkg::DATA_W-1:0] rise_val;
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: underflow, range extremes, duplicate max, non-max values
    send_item(mts_pkg::OP_POP,  $urandom);
    send_item(mts_pkg::OP_PUSH, 32'sh8000_0000);
    send_item(mts_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    send_item(mts_pkg::OP_PUSH, -32'sd1);
    send_item(mts_pkg::OP_PUSH, 32'sh7FFF_FFFF);
    repeat (5) send_item(mts_pkg::OP_POP, $urandom);
    send_item(mts_pkg::OP_POP,  '0);
    send_item(mts_pkg::OP_PUSH, 32'sd5);
    send_item(mts_pkg::OP_PUSH, 32'sd3);
    send_item(mts_pkg::OP_PUSH, 32'sd5);
    send_item(mts_pkg::OP_PUSH, 32'sd7);
    send_item(mts_pkg::OP_PUSH, 32'sd0);
    repeat (6) send_item(mts_pkg::OP_POP, $urandom);
    wait_all_results();

    // Random walk at moderate depth
    run_mixed(60, 60);

    // Climb to full without idling, then push into a full stack
    idle_ok  = 1'b0;
    rise_val = -32'sd1000;
    while (stack_sb.value_cnt < mts_pkg::DEPTH) begin
      if ($urandom_range(1) == 0) begin
        rise_val += int'($urandom_range(3));
        send_item(($urandom_range(99) < 98) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP, rise_val);
      end else begin
        send_item(($urandom_range(99) < 95) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP,
                  pick_value());
      end
    end
    repeat (3) send_item(mts_pkg::OP_PUSH, pick_value());
    send_item(mts_pkg::OP_POP,  $urandom);
    send_item(mts_pkg::OP_PUSH, pick_value());
    send_item(mts_pkg::OP_PUSH, pick_value());
    idle_ok = 1'b1;
    wait_all_results();

    // Walk back down with mostly pops
    run_mixed(140, 20);
    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (stack_sb.mismatches == 0 && stack_sb.awaited_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
